/* hdl/bpg_pkg.sv */
// Package with shared constants and types of the breathing PWM generator.
`timescale 1ns / 1ps

package bpg_pkg;

   // Fixed field widths
   localparam int COUNT_W    = 7;
   localparam int INT_W      = 7;
   localparam int Q16_W      = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   // Default fraction width of the duty level
   localparam int FRAC_BITS_DEFAULT = 16;

   // Register reset values
   localparam logic [COUNT_W-1:0] PERIOD_RESET = 7'd100;
   localparam logic [INT_W-1:0]   PEAK_RESET   = 7'd50;
   localparam logic [Q16_W-1:0]   FLOOR_RESET  = 16'd32768;
   localparam logic [Q16_W-1:0]   GAIN_RESET   = 16'd655;

   // Offset added to the level before scaling by the gain
   localparam int LEVEL_OFFSET = 5;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD = 2'd0,
      CSR_PEAK   = 2'd1,
      CSR_FLOOR  = 2'd2,
      CSR_GAIN   = 2'd3
   } csr_index_type;

endpackage

/* hdl/bpg_if.sv */
// Valid/ready channel interfaces of the breathing PWM generator.
`timescale 1ns / 1ps

// Tick channel
interface bpg_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

// Result channel
interface bpg_rsp_if;
   logic       valid;
   logic       ready;
   logic       pwm_out;
   logic       pwm_out_n;
   logic [6:0] duty_integer;
   logic       ramping_up;

   modport source (output valid, output pwm_out, output pwm_out_n,
                   output duty_integer, output ramping_up, input ready);
   modport sink   (input valid, input pwm_out, input pwm_out_n,
                   input duty_integer, input ramping_up, output ready);
endinterface

// Register write channel
interface bpg_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/breathing_pwm_generator.sv */
// Breathing PWM generator: top level with tick counter, ramp and result register.
//
// Usage:
//   req carries one tick per transaction (tick = 1 advances the generator,
//   tick = 0 only reports the current state). Every request transaction
//   yields exactly one rsp transaction with pwm_out, pwm_out_n, the integer
//   part of the duty level and the ramp direction after the update.
//   csr writes period, peak_level, floor_q16 and gain_q16 by index 0..3;
//   it is always ready and should be written only while the block is idle.
// Timing:
//   The result is registered and shows in the cycle after the request is
//   accepted. One transaction per cycle is sustained while rsp.ready is high;
//   the state update (counter, one 16 x (8+FRAC_BITS) multiply, saturating add and compares) is combinational.
// Reset:
//   Synchronous, active high. Counter goes to 0, level to 1.0, ramp up,
//   registers to their defaults, and no result is pending.
// Stall:
//   A result waits in the output register while rsp.ready is low; req.ready
//   is low only while that result is held, and rises in the cycle it leaves.
`timescale 1ns / 1ps

module breathing_pwm_generator
   import bpg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   bpg_req_if.sink   req,
   bpg_rsp_if.source rsp,
   bpg_csr_if.sink   csr
);

   localparam int LW = INT_W + FRAC_BITS;
   localparam logic [LW:0]   OFFSET_FIVE = (LW + 1)'(LEVEL_OFFSET) << FRAC_BITS;
   localparam logic [LW-1:0] LEVEL_MAX   = {LW{1'b1}};
   localparam logic [LW-1:0] LEVEL_ONE   = LW'(1) << FRAC_BITS;

   // Configuration registers
   logic [COUNT_W-1:0] period_ff;
   logic [INT_W-1:0]   peak_ff;
   logic [Q16_W-1:0]   floor_ff;
   logic [Q16_W-1:0]   gain_ff;

   // Generator state
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LW-1:0]      level_ff, level_in;
   logic               dir_up_ff, dir_up_in;

   // Result register
   logic               rsp_valid_ff;
   logic               pwm_ff;
   logic [INT_W-1:0]   duty_ff;
   logic               ramp_ff;

   logic               accept;
   logic [COUNT_W-1:0] count_inc;
   logic               wrap;
   logic [LW:0]        level_off;
   logic [LW+Q16_W:0]  product;
   logic [LW:0]        step;
   logic [LW+1:0]      sum;
   logic [LW-1:0]      level_up;
   logic [LW-1:0]      level_down;
   logic [LW-1:0]      level_step;
   logic [LW-1:0]      peak_level;
   logic [Q16_W+FRAC_BITS-1:0] floor_wide;
   logic [FRAC_BITS-1:0]       floor_level;

   // Handshakes
   assign csr.ready = 1'b1;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         peak_ff   <= PEAK_RESET;
         floor_ff  <= FLOOR_RESET;
         gain_ff   <= GAIN_RESET;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_PERIOD: period_ff <= csr.data[COUNT_W-1:0];
            CSR_PEAK:   peak_ff   <= csr.data[INT_W-1:0];
            CSR_FLOOR:  floor_ff  <= csr.data[Q16_W-1:0];
            CSR_GAIN:   gain_ff   <= csr.data[Q16_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Tick counter, wraps at the period
   assign count_inc = count_ff + COUNT_W'(1);
   always_comb begin
      count_in = (count_inc >= period_ff) ? '0 : count_inc;
   end
   assign wrap = (count_in == '0);

   // Exponential ramp step: gain * (level + 5), truncated to the level grid
   assign level_off = {1'b0, level_ff} + OFFSET_FIVE;
   assign product   = level_off * gain_ff;
   assign step      = product[LW+Q16_W:Q16_W];

   // Saturating up and down steps
   assign sum        = {2'b00, level_ff} + {1'b0, step};
   assign level_up   = (sum[LW+1:LW] != 2'b00) ? LEVEL_MAX : sum[LW-1:0];
   assign level_down = (step > {1'b0, level_ff}) ? '0 : (level_ff - step[LW-1:0]);
   assign level_step = dir_up_ff ? level_up : level_down;

   always_comb begin
      level_in = wrap ? level_step : level_ff;
   end

   // Turn points: peak first, floor wins
   assign peak_level  = {peak_ff, {FRAC_BITS{1'b0}}};
   assign floor_wide  = {floor_ff, {FRAC_BITS{1'b0}}};
   assign floor_level = floor_wide[Q16_W+FRAC_BITS-1:Q16_W];

   always_comb begin
      dir_up_in = dir_up_ff;
      if (level_in >= peak_level) begin
         dir_up_in = 1'b0;
      end
      if (level_in < {{INT_W{1'b0}}, floor_level}) begin
         dir_up_in = 1'b1;
      end
   end

   // State update on an accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         level_ff  <= LEVEL_ONE;
         dir_up_ff <= 1'b1;
      end else if (accept && req.tick) begin
         count_ff  <= count_in;
         level_ff  <= level_in;
         dir_up_ff <= dir_up_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (req.tick) begin
            pwm_ff  <= ({count_in, {FRAC_BITS{1'b0}}} < level_in);
            duty_ff <= level_in[LW-1:FRAC_BITS];
            ramp_ff <= dir_up_in;
         end else begin
            pwm_ff  <= ({count_ff, {FRAC_BITS{1'b0}}} < level_ff);
            duty_ff <= level_ff[LW-1:FRAC_BITS];
            ramp_ff <= dir_up_ff;
         end
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pwm_out      = pwm_ff;
   assign rsp.pwm_out_n    = !pwm_ff;
   assign rsp.duty_integer = duty_ff;
   assign rsp.ramping_up   = ramp_ff;

endmodule

/* hdl/bpg_checker.sv */
// Port-level checker of the breathing PWM generator and its bind.
`timescale 1ns / 1ps

module bpg_checker
   import bpg_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             pwm_out,
   input logic             pwm_out_n,
   input logic [INT_W-1:0] duty_integer,
   input logic             ramping_up
);

   // No result pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Complementary outputs
   a_complement: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pwm_out_n == !pwm_out))
      else $error("pwm_out_n is not the complement of pwm_out");

   // Every accepted transaction shows a result in the next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted transaction produced no result");

   // A held result blocks new requests
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted while result held");

   // Stalled result holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(pwm_out) && $stable(duty_integer) && $stable(ramping_up)))
      else $error("result changed during stall");

endmodule

bind breathing_pwm_generator bpg_checker u_bpg_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .pwm_out      (rsp.pwm_out),
   .pwm_out_n    (rsp.pwm_out_n),
   .duty_integer (rsp.duty_integer),
   .ramping_up   (rsp.ramping_up)
);
